// ===== rtl/ccrc8_pkg.sv =====
package ccrc8_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_INIT_VALUE  = 3'd0;
  localparam logic [2:0] REG_POLYNOMIAL  = 3'd1;
  localparam logic [2:0] REG_REFLECT_IN  = 3'd2;
  localparam logic [2:0] REG_REFLECT_OUT = 3'd3;
  localparam logic [2:0] REG_XOR_OUT     = 3'd4;

  localparam logic [7:0] INIT_VALUE_RST = 8'h00;
  localparam logic [7:0] POLYNOMIAL_RST = 8'h07;
  localparam logic       REFLECT_RST    = 1'b0;
  localparam logic [7:0] XOR_OUT_RST    = 8'h00;

  localparam logic [1:0] Q_FULL_CNT = 2'd2;

  typedef struct packed {
    logic [7:0] init_value;
    logic [7:0] polynomial;
    logic       reflect_in;
    logic       reflect_out;
    logic [7:0] xor_out;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] expected_crc;
  } item_t;

  typedef struct packed {
    logic [7:0] crc_value;
    logic       matches_res;
    logic       message_end;
  } res_t;

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = v[k];
    end
    return r;
  endfunction

  // eight MSB-first polynomial steps, unrolled
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] r;
    r = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ poly) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== rtl/ccrc8_regs.sv =====
module ccrc8_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ccrc8_pkg::ADDR_W-1:0]  paddr,
  input  logic [ccrc8_pkg::DATA_W-1:0]  pwdata,
  output logic [ccrc8_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output ccrc8_pkg::cfg_t               cfg
);

  ccrc8_pkg::cfg_t cfg_r;
  ccrc8_pkg::cfg_t cfg_nxt;
  logic            wr_en;
  logic [2:0]      idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        ccrc8_pkg::REG_INIT_VALUE:  cfg_nxt.init_value  = pwdata[7:0];
        ccrc8_pkg::REG_POLYNOMIAL:  cfg_nxt.polynomial  = pwdata[7:0];
        ccrc8_pkg::REG_REFLECT_IN:  cfg_nxt.reflect_in  = pwdata[0];
        ccrc8_pkg::REG_REFLECT_OUT: cfg_nxt.reflect_out = pwdata[0];
        ccrc8_pkg::REG_XOR_OUT:     cfg_nxt.xor_out     = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_value  <= ccrc8_pkg::INIT_VALUE_RST;
      cfg_r.polynomial  <= ccrc8_pkg::POLYNOMIAL_RST;
      cfg_r.reflect_in  <= ccrc8_pkg::REFLECT_RST;
      cfg_r.reflect_out <= ccrc8_pkg::REFLECT_RST;
      cfg_r.xor_out     <= ccrc8_pkg::XOR_OUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      ccrc8_pkg::REG_INIT_VALUE:  prdata = {24'd0, cfg_r.init_value};
      ccrc8_pkg::REG_POLYNOMIAL:  prdata = {24'd0, cfg_r.polynomial};
      ccrc8_pkg::REG_REFLECT_IN:  prdata = {31'd0, cfg_r.reflect_in};
      ccrc8_pkg::REG_REFLECT_OUT: prdata = {31'd0, cfg_r.reflect_out};
      ccrc8_pkg::REG_XOR_OUT:     prdata = {24'd0, cfg_r.xor_out};
      default:                    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/ccrc8_front.sv =====
module ccrc8_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic [7:0]       expected_crc,
  input  logic             reflect_in,
  output logic             head_valid,
  output ccrc8_pkg::item_t head,
  input  logic             take
);

  ccrc8_pkg::item_t mem_r [2];
  ccrc8_pkg::item_t wr_item;
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_take;

  assign full       = (cnt_r == ccrc8_pkg::Q_FULL_CNT);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_take    = take && head_valid;

  // input reflection is applied on entry
  always_comb begin
    wr_item.data_byte    = reflect_in ? ccrc8_pkg::bit_rev8(data_byte) : data_byte;
    wr_item.last_byte    = last_byte;
    wr_item.expected_crc = expected_crc;
  end

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_take ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== rtl/ccrc8_back.sv =====
module ccrc8_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ccrc8_pkg::cfg_t  cfg,
  input  logic             head_valid,
  input  ccrc8_pkg::item_t head,
  output logic             take,
  output logic             empty,
  input  logic             pop,
  output ccrc8_pkg::res_t  res
);

  logic [7:0]       crc_r, crc_nxt;
  logic [7:0]       crc_calc;
  logic [7:0]       crc_fin;
  ccrc8_pkg::res_t  wr_res;
  ccrc8_pkg::res_t  mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_pop;

  assign take   = head_valid && (cnt_r != ccrc8_pkg::Q_FULL_CNT);
  assign empty  = (cnt_r == 2'd0);
  assign do_pop = pop && !empty;
  assign res    = mem_r[rd_ptr_r];

  always_comb begin
    crc_calc           = ccrc8_pkg::crc8_byte(crc_r, head.data_byte, cfg.polynomial);
    crc_fin            = (cfg.reflect_out ? ccrc8_pkg::bit_rev8(crc_calc) : crc_calc)
                         ^ cfg.xor_out;
    wr_res.crc_value   = crc_fin;
    wr_res.matches_res = (crc_fin == head.expected_crc);
    wr_res.message_end = head.last_byte;
    crc_nxt            = crc_r;
    if (take) begin
      crc_nxt = head.last_byte ? cfg.init_value : crc_calc;
    end
  end

  always_comb begin
    wr_ptr_nxt = take ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, take} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= ccrc8_pkg::INIT_VALUE_RST;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      crc_r    <= crc_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mem_r[wr_ptr_r] <= wr_res;
    end
  end

endmodule

// ===== rtl/configurable_crc8_engine.sv =====
// A byte is registered in the input queue, then its result in the result queue.
// Throughput: one byte per cycle unless the result queue is full; the CRC update
// is one unrolled XOR network per byte in the back stage, fed from a 2-entry queue
// behind the input. A 2-entry result queue lets input keep flowing while a result
// waits for pop. Reset (rst_n low, synchronous): queues empty, CRC register and
// config registers return to their reset values.
module configurable_crc8_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_last_byte,
  input  logic [7:0]                   in_expected_crc,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   out_crc_value,
  output logic                         out_matches_res,
  output logic                         out_message_end,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ccrc8_pkg::ADDR_W-1:0] paddr,
  input  logic [ccrc8_pkg::DATA_W-1:0] pwdata,
  output logic [ccrc8_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  ccrc8_pkg::cfg_t  cfg;
  ccrc8_pkg::item_t head;
  ccrc8_pkg::res_t  res;
  logic             head_valid;
  logic             take;

  ccrc8_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccrc8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .data_byte    (in_data_byte),
    .last_byte    (in_last_byte),
    .expected_crc (in_expected_crc),
    .reflect_in   (cfg.reflect_in),
    .head_valid   (head_valid),
    .head         (head),
    .take         (take)
  );

  ccrc8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .empty      (empty),
    .pop        (pop),
    .res        (res)
  );

  assign out_crc_value   = res.crc_value;
  assign out_matches_res = res.matches_res;
  assign out_message_end = res.message_end;

endmodule

// ===== rtl/ccrc8_checker.sv =====
module ccrc8_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_crc_value,
  input logic       out_message_end
);

  logic [2:0] outst_r, outst_nxt;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  always_comb begin
    outst_nxt = outst_r + {2'd0, in_xfer} - {2'd0, out_xfer};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outst_r <= 3'd0;
    end else begin
      outst_r <= outst_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> outst_r != 3'd0)
    else $error("result shown with no byte outstanding");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && outst_r == 3'd0 |-> ##2 !empty)
    else $error("result did not appear two cycles after transfer");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_crc_value) && $stable(out_message_end))
    else $error("waiting result changed");

endmodule

bind configurable_crc8_engine ccrc8_checker u_ccrc8_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .push            (push),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .out_crc_value   (out_crc_value),
  .out_message_end (out_message_end)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned RX_HOLD_CYCLES = 200;
  localparam int unsigned RAND_ITEMS     = 1330;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned N_DIR_ROWS     = 33;
  localparam logic [2:0]  REG_UNMAPPED   = 3'd6;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [31:0] wdata;
    logic [7:0]  data;
    logic        last;
    logic [7:0]  exp_crc;
    bit          typed;
    logic [7:0]  crc;
    logic        match;
  } dir_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           push;
  logic                           full;
  logic [7:0]                     in_data_byte;
  logic                           in_last_byte;
  logic [7:0]                     in_expected_crc;
  logic                           empty;
  logic                           pop;
  logic [7:0]                     out_crc_value;
  logic                           out_matches_res;
  logic                           out_message_end;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [ccrc8_pkg::ADDR_W-1:0]   paddr;
  logic [ccrc8_pkg::DATA_W-1:0]   pwdata;
  logic [ccrc8_pkg::DATA_W-1:0]   prdata;
  logic                           pready;

  ccrc8_pkg::cfg_t                model_cfg;
  logic [7:0]                     crc_acc;
  ccrc8_pkg::res_t                crc_expect_q[$];
  int unsigned                    fault_cnt = 0;
  int unsigned                    cycle_cnt = 0;
  bit                             tx_idle = 1'b1;
  bit                             rx_idle = 1'b1;
  bit                             rx_hold_req = 1'b0;

  // rows: kind, register, write data, byte, last, expected crc, typed, crc, match
  dir_row_t dir_rows [N_DIR_ROWS] = '{
    '{ROW_ITEM, 3'd0, 32'h0, 8'h00, 1'b1, 8'h00, 1'b1, 8'h00, 1'b1},
    '{ROW_ITEM, 3'd0, 32'h0, 8'h01, 1'b1, 8'h07, 1'b1, 8'h07, 1'b1},
    '{ROW_ITEM, 3'd0, 32'h0, 8'h01, 1'b1, 8'hFF, 1'b1, 8'h07, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'h80, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'h7F, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'hAA, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'h55, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    // init change mid-message: applies only after the next last byte
    '{ROW_CFG, ccrc8_pkg::REG_INIT_VALUE, 32'hFFFF_FFA5, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'h3C, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'h3C, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG, ccrc8_pkg::REG_POLYNOMIAL, 32'h0000_0031, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG, ccrc8_pkg::REG_REFLECT_IN, 32'hFFFF_FFFF, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG, ccrc8_pkg::REG_REFLECT_OUT, 32'h0000_0001, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG, ccrc8_pkg::REG_XOR_OUT, 32'hFFFF_FFFF, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'h31, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'h12, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0},
    // zero polynomial clears the register, so the result is just xor_out
    '{ROW_CFG, ccrc8_pkg::REG_POLYNOMIAL, 32'h0000_0000, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'h5A, 1'b1, 8'hFF, 1'b1, 8'hFF, 1'b1},
    '{ROW_CFG, ccrc8_pkg::REG_POLYNOMIAL, 32'h0000_00FF, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'h00, 1'b0, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'h01, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG, REG_UNMAPPED, 32'h0000_00FF, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'h81, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG, ccrc8_pkg::REG_INIT_VALUE, 32'h0000_0000, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG, ccrc8_pkg::REG_REFLECT_IN, 32'hFFFF_FFFE, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG, ccrc8_pkg::REG_REFLECT_OUT, 32'h0000_0000, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG, ccrc8_pkg::REG_XOR_OUT, 32'hABCD_EF00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG, ccrc8_pkg::REG_POLYNOMIAL, 32'h0000_0107, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, 3'd0, 32'h0, 8'h01, 1'b1, 8'h07, 1'b1, 8'h07, 1'b1},
    '{ROW_ITEM, 3'd0, 32'h0, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0}
  };

  configurable_crc8_engine DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .in_expected_crc (in_expected_crc),
    .empty           (empty),
    .pop             (pop),
    .out_crc_value   (out_crc_value),
    .out_matches_res (out_matches_res),
    .out_message_end (out_message_end),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[configurable_crc8_engine] ERROR");
      $finish;
    end
  end

  task automatic log_fault(input string what);
    fault_cnt++;
    if (fault_cnt <= MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    end
  endtask

  function automatic logic [7:0] crc_shift_byte(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] d;
    logic [7:0] r;
    d = data;
    if (model_cfg.reflect_in) begin
      d = {<<{data}};
    end
    r = acc ^ d;
    repeat (8) begin
      if (r[7]) begin
        r = (r << 1) ^ model_cfg.polynomial;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  function automatic ccrc8_pkg::res_t crc_predict(input ccrc8_pkg::item_t it);
    logic [7:0]      nxt;
    logic [7:0]      v;
    ccrc8_pkg::res_t r;
    nxt = crc_shift_byte(crc_acc, it.data_byte);
    v = nxt;
    if (model_cfg.reflect_out) begin
      v = {<<{nxt}};
    end
    v = v ^ model_cfg.xor_out;
    r.crc_value   = v;
    r.matches_res = (v == it.expected_crc);
    r.message_end = it.last_byte;
    return r;
  endfunction

  task automatic offer_byte(input ccrc8_pkg::item_t it, input bit typed,
                            input ccrc8_pkg::res_t typed_res);
    int unsigned     gap;
    ccrc8_pkg::res_t want;
    gap  = tx_idle ? $urandom_range(0, 13) : 0;
    want = typed ? typed_res : crc_predict(it);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push            <= 1'b1;
    in_data_byte    <= it.data_byte;
    in_last_byte    <= it.last_byte;
    in_expected_crc <= it.expected_crc;
    do @(posedge clk); while (full);
    crc_expect_q.push_back(want);
    crc_acc = it.last_byte ? model_cfg.init_value : crc_shift_byte(crc_acc, it.data_byte);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (crc_expect_q.size() != 0);
  endtask

  // write, then read back; unmapped addresses are only written
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mask = 32'hFF;
    case (idx)
      ccrc8_pkg::REG_INIT_VALUE:  model_cfg.init_value  = value[7:0];
      ccrc8_pkg::REG_POLYNOMIAL:  model_cfg.polynomial  = value[7:0];
      ccrc8_pkg::REG_REFLECT_IN:  begin
        model_cfg.reflect_in = value[0];
        mask = 32'h1;
      end
      ccrc8_pkg::REG_REFLECT_OUT: begin
        model_cfg.reflect_out = value[0];
        mask = 32'h1;
      end
      ccrc8_pkg::REG_XOR_OUT:     model_cfg.xor_out     = value[7:0];
      default: ;
    endcase
    if (idx <= ccrc8_pkg::REG_XOR_OUT) begin
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      got = prdata;
      if (got !== (value & mask)) begin
        log_fault($sformatf("register %0d read %08h, expected %08h", idx, got, value & mask));
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic randomize_settings();
    logic [31:0] value;
    for (int i = 0; i <= ccrc8_pkg::REG_XOR_OUT; i++) begin
      if ($urandom_range(0, 2) != 0) begin
        value = $urandom;
        case ($urandom_range(0, 3))
          0:       value[7:0] = 8'h00;
          1:       value[7:0] = 8'hFF;
          default: ;
        endcase
        cfg_write(3'(i), value);
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      cfg_write(3'($urandom_range(5, 7)), $urandom);
    end
  endtask

  // result side
  initial begin
    int unsigned     stall;
    ccrc8_pkg::res_t want;
    pop = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = rx_idle ? $urandom_range(0, 13) : 0;
        if (stall != 0) begin
          pop <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (crc_expect_q.size() == 0) begin
        log_fault($sformatf("transfer with nothing expected: crc %02h match %0b end %0b",
                            out_crc_value, out_matches_res, out_message_end));
      end else begin
        want = crc_expect_q.pop_front();
        if (out_crc_value !== want.crc_value || out_matches_res !== want.matches_res ||
            out_message_end !== want.message_end) begin
          log_fault($sformatf("crc %02h/%02h match %0b/%0b end %0b/%0b (expected/actual)",
                              want.crc_value, out_crc_value, want.matches_res,
                              out_matches_res, want.message_end, out_message_end));
        end
      end
    end
  end

  // input side and configuration
  initial begin
    ccrc8_pkg::item_t it;
    ccrc8_pkg::res_t  typed_res;
    ccrc8_pkg::res_t  peek;
    int unsigned      sent;
    int unsigned      phase;
    int unsigned      phase_len;
    int unsigned      msg_left;
    rst_n           = 1'b0;
    push            = 1'b0;
    in_data_byte    = 8'h00;
    in_last_byte    = 1'b0;
    in_expected_crc = 8'h00;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    model_cfg.init_value  = ccrc8_pkg::INIT_VALUE_RST;
    model_cfg.polynomial  = ccrc8_pkg::POLYNOMIAL_RST;
    model_cfg.reflect_in  = ccrc8_pkg::REFLECT_RST;
    model_cfg.reflect_out = ccrc8_pkg::REFLECT_RST;
    model_cfg.xor_out     = ccrc8_pkg::XOR_OUT_RST;
    crc_acc = ccrc8_pkg::INIT_VALUE_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drained();
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].wdata);
      end else begin
        it.data_byte    = dir_rows[i].data;
        it.last_byte    = dir_rows[i].last;
        it.expected_crc = dir_rows[i].exp_crc;
        typed_res.crc_value   = dir_rows[i].crc;
        typed_res.matches_res = dir_rows[i].match;
        typed_res.message_end = dir_rows[i].last;
        offer_byte(it, dir_rows[i].typed, typed_res);
      end
    end

    sent     = 0;
    phase    = 0;
    msg_left = 0;
    while (sent < RAND_ITEMS) begin
      wait_drained();
      randomize_settings();
      tx_idle   = ($urandom_range(0, 3) != 0);
      rx_idle   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(20, 90);
      if (phase == 2) begin
        // back-pressure: receiver stalls while the sender keeps offering
        tx_idle     = 1'b0;
        rx_hold_req = 1'b1;
        phase_len   = 90;
      end
      repeat (phase_len) begin
        if ($urandom_range(0, 59) == 0) begin
          wait_drained();
        end
        if (msg_left == 0) begin
          msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                 : $urandom_range(1, 16);
        end
        it.data_byte    = 8'($urandom_range(0, 255));
        it.last_byte    = (msg_left == 1);
        it.expected_crc = 8'($urandom_range(0, 255));
        msg_left--;
        if ($urandom_range(0, 1) != 0) begin
          peek = crc_predict(it);
          it.expected_crc = peek.crc_value;
        end
        offer_byte(it, 1'b0, typed_res);
        sent++;
      end
      phase++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fault_cnt == 0 && crc_expect_q.size() == 0) begin
      $display("[configurable_crc8_engine] OK");
    end else begin
      $display("[configurable_crc8_engine] ERROR");
    end
    $finish;
  end

endmodule

// ===== configurable_crc8_engine.f =====
rtl/ccrc8_pkg.sv
rtl/ccrc8_regs.sv
rtl/ccrc8_front.sv
rtl/ccrc8_back.sv
rtl/configurable_crc8_engine.sv
rtl/ccrc8_checker.sv
bench/tb.sv
